// File: rtl/msft_pkg.sv
// msft_pkg: shared types and constants of the maximal set filter table
// no dependencies; imported by maximal_set_filter_table
`timescale 1ns / 1ps

package msft_pkg;

	// width of the candidate mask as it travels on the input stream
	localparam int unsigned MEMBERS_W = 64;
	// width of the count fields of a result
	localparam int unsigned CNT_W     = 7;

	// action codes carried in the input tuser
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// one result, first field in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0] occupancy;
		logic             table_full;
		logic [CNT_W-1:0] removed_count;
		logic             accepted;
	} result_t;

endpackage

// File: rtl/maximal_set_filter_table.sv
// maximal_set_filter_table: top level, table of maximal sets with subset pruning
// depends on msft_pkg and msft_ram
`timescale 1ns / 1ps

// The block keeps up to SLOTS sets, each a mask over TRAJECTORIES members,
// such that no stored set contains another. Every input transaction gives
// exactly one result transaction. An insert (tuser = 0) carries a candidate
// mask in tdata; bits at and above TRAJECTORIES are ignored. The candidate
// is rejected when some stored set equals or contains it; otherwise every
// stored set that it contains is erased and the candidate goes to the
// lowest free slot, or is dropped with table_full set when no slot is free.
// A clear (tuser = 1) empties the table. All state lives in one memory of
// SLOTS words (a valid bit over the member mask) with a single read port,
// so timing is set by one entry read per cycle: a rejected or dropped
// insert takes one scan, a stored insert a scan and then a second pass
// that erases subsets and writes the new entry, and a clear one clearing
// pass. After reset a clearing pass runs before the first transaction is
// taken. The finished result sits in an output register, so the next item
// is taken while the previous result still waits on the output side.
// Counts wider than 7 bits (SLOTS above 127) are reported in their low 7
// bits.

module maximal_set_filter_table #(
	parameter int unsigned SLOTS        = 64,
	parameter int unsigned TRAJECTORIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [msft_pkg::MEMBERS_W-1:0]   s_tdata,  // members[63:0]
	input  logic [0:0]                       s_tuser,  // action[0]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [$bits(msft_pkg::result_t)-1:0] m_tdata
	// m_tdata: accepted[0], removed_count[7:1], table_full[8], occupancy[15:9]
);

	import msft_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned WW = TRAJECTORIES + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLEAR  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]              state_q;
	logic [AW-1:0]           addr_q;       // read or clear address
	logic                    issue_q;      // a read is issued this cycle
	logic                    rd_s1;        // read data valid
	logic [AW-1:0]           addr_s1;
	logic                    last_s1;
	logic [TRAJECTORIES-1:0] cand_q;
	logic                    covered_q;    // some entry contains the candidate
	logic                    free_found_q;
	logic [AW-1:0]           free_idx_q;   // lowest slot free after pruning
	logic [CW-1:0]           removed_q;
	logic [CW-1:0]           count_q;      // valid entries
	logic                    reply_q;      // clear pass answers a transaction
	result_t                 res_q;        // finished result awaiting output
	result_t                 out_q;
	logic                    out_valid_q;

	// memory port signals
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [WW-1:0]           ram_wdata;
	logic [WW-1:0]           ram_rdata;

	// entry seen on the read data
	logic                    ent_valid;
	logic [TRAJECTORIES-1:0] ent_members;
	logic                    ent_super;    // entry contains candidate
	logic                    ent_sub;      // entry lies inside candidate
	logic                    ent_free;     // slot usable once pruned
	logic                    is_free_slot;
	logic                    in_xact;
	logic                    out_load;

	msft_ram #(
		.DEPTH (SLOTS),
		.WIDTH (WW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign ent_valid    = ram_rdata[TRAJECTORIES];
	assign ent_members  = ram_rdata[TRAJECTORIES-1:0];
	assign ent_super    = ent_valid && ((cand_q & ~ent_members) == '0);
	assign ent_sub      = ent_valid && ((ent_members & ~cand_q) == '0);
	assign ent_free     = !ent_valid || ent_sub;
	assign is_free_slot = (addr_s1 == free_idx_q);

	// clear pass writes invalid words; update pass erases subsets and
	// places the candidate in the cycle after its own read of the same slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = {1'b0, ent_members};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = '0;
			end
			ST_UPDATE: begin
				ram_we = rd_s1 && (ent_sub || is_free_slot);
				if (is_free_slot) begin
					ram_wdata = {1'b1, cand_q};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xact  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			rd_s1        <= 1'b0;
			last_s1      <= 1'b0;
			covered_q    <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			removed_q    <= '0;
			count_q      <= '0;
			reply_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// read pipeline
			rd_s1   <= issue_q;
			last_s1 <= issue_q && (addr_q == LAST_ADDR);
			if (issue_q) begin
				addr_q <= addr_q + AW'(1);
				if (addr_q == LAST_ADDR) begin
					issue_q <= 1'b0;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						addr_q       <= '0;
						covered_q    <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= '0;
						if (s_tuser[0] == ACT_CLEAR) begin
							reply_q <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR) begin
						count_q <= '0;
						state_q <= reply_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (rd_s1) begin
						if (ent_super) begin
							covered_q <= 1'b1;
						end
						if (ent_sub) begin
							removed_q <= removed_q + CW'(1);
						end
						if (ent_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= addr_s1;
						end
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (covered_q || !free_found_q) begin
						state_q <= ST_DONE;
					end else begin
						addr_q  <= '0;
						issue_q <= 1'b1;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (rd_s1 && last_s1) begin
						count_q <= count_q - removed_q + CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, built as the work ends
	always_ff @(posedge clk) begin
		if (in_xact) begin
			cand_q <= s_tdata[TRAJECTORIES-1:0];
		end
		if (rd_s1) begin
			addr_s1 <= addr_q;
		end else begin
			addr_s1 <= addr_q;
		end
		unique case (state_q)
			ST_CLEAR: begin
				res_q <= '0;
			end
			ST_DECIDE: begin
				res_q.accepted      <= 1'b0;
				res_q.removed_count <= '0;
				res_q.table_full    <= !covered_q && !free_found_q;
				res_q.occupancy     <= CNT_W'(count_q);
			end
			ST_UPDATE: begin
				res_q.accepted      <= 1'b1;
				res_q.removed_count <= CNT_W'(removed_q);
				res_q.table_full    <= 1'b0;
				res_q.occupancy     <= CNT_W'(count_q - removed_q + CW'(1));
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// a result never claims both storage and a full table
	a_accept_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.accepted && out_q.table_full))
		else $error("accepted and table_full both set");

	// erased subsets always leave room, so removal implies storage
	a_removed_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.removed_count != '0)) |-> out_q.accepted)
		else $error("entries removed without storing the candidate");

	// occupancy stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("valid count beyond table size");

	// the memory is written only by the clear and update passes
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
		else $error("table write outside clear or update pass");

	// an accepted transaction always starts work
	a_start_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> (state_q == ST_CLEAR || state_q == ST_SCAN))
		else $error("accepted transaction did not start a pass");

endmodule

// File: rtl/msft_ram.sv
// msft_ram: single-clock table memory, one write port and one read port
// read data registered; no package dependencies
`timescale 1ns / 1ps

module msft_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 65,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
